/* hdl/esc_pkg.sv */
// esc_pkg: types, constants and constant tables for the epoch seconds to calendar unit
// standalone package, no dependencies
package esc_pkg;

   localparam int EPOCH_YEAR = 1970;
   localparam int NUM_YEARS  = 137;
   localparam int NUM_STAGES = 13;

   localparam int OFFSET_W = 17;
   localparam int EPOCH_W  = 32;
   localparam int LOCAL_W  = 33;

   // reset value of the offset register
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd28800;

   // days = (t >> 7) / 675, via reciprocal; exact for 26-bit operands
   localparam int          DAY_SHIFT = 36;
   localparam logic [26:0] DAY_RECIP = 27'd101806633;
   localparam logic [9:0]  DAY_ODD   = 10'd675;

   // hour = (secs >> 4) / 225
   localparam int          HOUR_SHIFT = 21;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [16:0] SECS_HOUR  = 17'd3600;

   // minute = (rem >> 2) / 15
   localparam int          MIN_SHIFT = 14;
   localparam logic [10:0] MIN_RECIP = 11'd1093;
   localparam logic [11:0] SECS_MIN  = 12'd60;

   localparam int SEARCH_FIRST = 2;
   localparam int SEARCH_LAST  = 9;

   typedef logic [15:0] year_start_type [0:255];
   typedef logic [8:0]  month_row_type  [0:12];
   typedef month_row_type month_table_type [0:1];

   typedef struct packed {
      logic [LOCAL_W-1:0] t;
      logic [15:0]        days;
      logic [16:0]        secs;
      logic [4:0]         hour;
      logic [11:0]        rem_h;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [7:0]         yidx;
      logic [8:0]         doy;
      logic               leap;
      logic [3:0]         month;
      logic [4:0]         dom;
   } stage_type;

   // days before the first of each month, common year then leap year
   localparam month_table_type MONTH_START = '{
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
   };

   function automatic logic is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // day number of january 1 of each year; unused entries never match
   function automatic year_start_type build_year_start();
      year_start_type tbl;
      int unsigned acc;
      acc = 0;
      for (int i = 0; i < 256; i++) begin
         if (i < NUM_YEARS) begin
            tbl[i] = 16'(acc);
         end else begin
            tbl[i] = 16'hFFFF;
         end
         acc = acc + (is_leap(EPOCH_YEAR + i) ? 366 : 365);
      end
      return tbl;
   endfunction

   function automatic logic [255:0] build_leap_table();
      logic [255:0] tbl;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = is_leap(EPOCH_YEAR + i);
      end
      return tbl;
   endfunction

   localparam year_start_type YEAR_START = build_year_start();
   localparam logic [255:0]   LEAP_TABLE = build_leap_table();

endpackage

/* hdl/epoch_seconds_to_calendar_unit.sv */
// epoch_seconds_to_calendar_unit: top level, pipelined epoch seconds to local date and time
// depends on esc_pkg for constants, year start table and the stage record

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC into local
// year, month, day of month, hour, minute and second. The local time is the input plus the
// signed 17-bit offset held in the csr register (reset 28800); a negative local time clamps
// to 1970-01-01 00:00:00. The datapath is a 13-stage pipeline: the day count and the time of
// day come from reciprocal multiplies, and the year from an eight-step binary search over a
// constant table of year start days, one step per stage. A request is taken every cycle while
// the response side takes results; a stalled response holds the whole pipeline. Write the
// offset only while no request is in flight.
module epoch_seconds_to_calendar_unit
   import esc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic signed [OFFSET_W-1:0] csr_utc_offset_seconds,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [EPOCH_W-1:0]         req_epoch_seconds,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [11:0]                rsp_year,
   output logic [3:0]                 rsp_month,
   output logic [4:0]                 rsp_day_of_month,
   output logic [4:0]                 rsp_hour,
   output logic [5:0]                 rsp_minute,
   output logic [5:0]                 rsp_second
);

   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic [NUM_STAGES-1:0]      valid_ff, valid_in;
   stage_type                  pipe_ff [NUM_STAGES];
   stage_type                  pipe_in [NUM_STAGES];
   logic                       advance;
   logic signed [LOCAL_W:0]    local_sum;

   // work done on the way into register k
   function automatic stage_type stage_step(logic [3:0] k, stage_type p);
      stage_type    q;
      logic [2:0]   bitpos;
      logic [7:0]   cand;
      logic [52:0]  day_prod;
      logic [25:0]  q1;
      logic [25:0]  rem_day;
      logic [26:0]  hour_prod;
      logic [20:0]  min_prod;
      logic [16:0]  secs_left;
      logic [11:0]  min_left;
      logic [3:0]   count;
      q = p;
      q1 = p.t[LOCAL_W-1:7];
      // binary search for the last year that starts on or before days
      if (k >= 4'(SEARCH_FIRST) && k <= 4'(SEARCH_LAST)) begin
         bitpos = 3'(4'(SEARCH_LAST) - k);
         cand = p.yidx | (8'd1 << bitpos);
         if (YEAR_START[cand] <= p.days) begin
            q.yidx = cand;
         end
      end
      unique case (k)
         4'd1: begin
            day_prod = 53'(q1) * 53'(DAY_RECIP);
            q.days = day_prod[DAY_SHIFT +: 16];
         end
         4'd2: begin
            rem_day = q1 - 26'(p.days) * 26'(DAY_ODD);
            q.secs = {rem_day[9:0], p.t[6:0]};
         end
         4'd3: begin
            hour_prod = 27'(p.secs[16:4]) * 27'(HOUR_RECIP);
            q.hour = hour_prod[HOUR_SHIFT +: 5];
         end
         4'd4: begin
            secs_left = p.secs - 17'(p.hour) * SECS_HOUR;
            q.rem_h = secs_left[11:0];
         end
         4'd5: begin
            min_prod = 21'(p.rem_h[11:2]) * 21'(MIN_RECIP);
            q.minute = min_prod[MIN_SHIFT +: 6];
         end
         4'd6: begin
            min_left = p.rem_h - 12'(p.minute) * SECS_MIN;
            q.second = min_left[5:0];
         end
         4'd10: begin
            q.doy  = 9'(p.days - YEAR_START[p.yidx]);
            q.leap = LEAP_TABLE[p.yidx];
         end
         4'd11: begin
            count = 4'd1;
            for (int m = 1; m < 12; m++) begin
               if (p.doy >= MONTH_START[p.leap][m]) begin
                  count = count + 4'd1;
               end
            end
            q.month = count;
         end
         4'd12: begin
            q.dom = 5'(p.doy - MONTH_START[p.leap][p.month - 4'd1] + 9'd1);
         end
         default: begin
            q = q;
         end
      endcase
      return q;
   endfunction

   assign csr_ready = 1'b1;
   assign advance   = !valid_ff[NUM_STAGES-1] || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      offset_in = offset_ff;
      if (csr_valid) begin
         offset_in = csr_utc_offset_seconds;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   // stage 0: apply the offset and clamp negative local time
   assign local_sum = $signed({2'b00, req_epoch_seconds})
                    + (LOCAL_W+1)'(offset_ff);

   always_comb begin
      pipe_in[0] = '0;
      if (!local_sum[LOCAL_W]) begin
         pipe_in[0].t = local_sum[LOCAL_W-1:0];
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         pipe_in[k] = stage_step(4'(k), pipe_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         valid_ff  <= '0;
      end else begin
         offset_ff <= offset_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   assign rsp_valid        = valid_ff[NUM_STAGES-1];
   assign rsp_year         = 12'(EPOCH_YEAR) + 12'(pipe_ff[NUM_STAGES-1].yidx);
   assign rsp_month        = pipe_ff[NUM_STAGES-1].month;
   assign rsp_day_of_month = pipe_ff[NUM_STAGES-1].dom;
   assign rsp_hour         = pipe_ff[NUM_STAGES-1].hour;
   assign rsp_minute       = pipe_ff[NUM_STAGES-1].minute;
   assign rsp_second       = pipe_ff[NUM_STAGES-1].second;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved while the response was stalled");

   a_doy_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[10] |-> pipe_ff[10].doy <= 9'd365)
      else $error("day of year out of range after year search");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12
                     && rsp_day_of_month >= 5'd1))
      else $error("month or day of month out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("time of day out of range");

endmodule

/* bench/tb_calendar_pkg.sv */
// tb_calendar_pkg: calendar prediction and result scoreboard for the epoch to calendar bench
// depends on esc_pkg for the offset width only
package tb_calendar_pkg;
   import esc_pkg::OFFSET_W;

   localparam longint SECS_IN_MINUTE = 60;
   localparam longint SECS_IN_HOUR   = 3600;
   localparam longint SECS_IN_DAY    = 86400;
   localparam int     FIRST_YEAR     = 1970;

   // days before the first of each month, common year then leap year
   localparam int CUM_DAYS [2][13] = '{
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
      '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
   };

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   function automatic bit year_is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // local seconds since the epoch for a given local date and time
   function automatic longint local_seconds(int y, int mo, int d, int hh, int mi, int ss);
      longint days;
      int lp;
      days = 0;
      for (int k = FIRST_YEAR; k < y; k++) days += year_is_leap(k) ? 366 : 365;
      lp = year_is_leap(y);
      days += CUM_DAYS[lp][mo-1] + d - 1;
      return days * SECS_IN_DAY + hh * SECS_IN_HOUR + mi * SECS_IN_MINUTE + ss;
   endfunction

   function automatic calendar_type to_calendar(logic [31:0] epoch,
                                                logic signed [OFFSET_W-1:0] ofs);
      longint lt;
      longint days;
      longint rem;
      int y;
      int ylen;
      int m;
      int lp;
      calendar_type c;
      lt = longint'(epoch) + longint'(ofs);
      // local time before the epoch pins to the epoch itself
      if (lt < 0) lt = 0;
      days = lt / SECS_IN_DAY;
      rem  = lt % SECS_IN_DAY;
      y = FIRST_YEAR;
      ylen = year_is_leap(y) ? 366 : 365;
      while (days >= ylen) begin
         days -= ylen;
         y++;
         ylen = year_is_leap(y) ? 366 : 365;
      end
      lp = year_is_leap(y);
      m = 1;
      while (m < 12 && days >= CUM_DAYS[lp][m]) m++;
      days -= CUM_DAYS[lp][m-1];
      c.year   = 12'(y);
      c.month  = 4'(m);
      c.day    = 5'(days + 1);
      c.hour   = 5'(rem / SECS_IN_HOUR);
      c.minute = 6'((rem % SECS_IN_HOUR) / SECS_IN_MINUTE);
      c.second = 6'(rem % SECS_IN_MINUTE);
      return c;
   endfunction

   class calendar_scoreboard;
      logic signed [OFFSET_W-1:0] offset;
      calendar_type due_dates[$];
      int errors;

      function new();
         offset = 17'sd28800;
         errors = 0;
      endfunction

      function void set_offset(logic signed [OFFSET_W-1:0] value);
         offset = value;
      endfunction

      function int pending();
         return due_dates.size();
      endfunction

      function void note_request(logic [31:0] epoch);
         due_dates.push_back(to_calendar(epoch, offset));
      endfunction

      function void check_response(calendar_type got);
         calendar_type want;
         if (due_dates.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response %0d-%0d-%0d %0d:%0d:%0d, none outstanding",
                        got.year, got.month, got.day, got.hour, got.minute, got.second);
            return;
         end
         want = due_dates.pop_front();
         if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
             got.hour !== want.hour || got.minute !== want.minute ||
             got.second !== want.second) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                        want.year, want.month, want.day, want.hour, want.minute, want.second,
                        got.year, got.month, got.day, got.hour, got.minute, got.second);
         end
      endfunction
   endclass

endpackage

/* bench/tb_epoch_seconds_to_calendar_unit.sv */
// tb_epoch_seconds_to_calendar_unit: bench top, drives requests, offset writes and response stalls
// depends on esc_pkg, tb_calendar_pkg and the epoch_seconds_to_calendar_unit rtl
module tb_epoch_seconds_to_calendar_unit
   import esc_pkg::*, tb_calendar_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic signed [OFFSET_W-1:0] csr_utc_offset_seconds;
   logic                       req_valid;
   logic                       req_ready;
   logic [EPOCH_W-1:0]         req_epoch_seconds;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [11:0]                rsp_year;
   logic [3:0]                 rsp_month;
   logic [4:0]                 rsp_day_of_month;
   logic [4:0]                 rsp_hour;
   logic [5:0]                 rsp_minute;
   logic [5:0]                 rsp_second;

   calendar_scoreboard sb = new();
   int idle_pct = 0;

   epoch_seconds_to_calendar_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_utc_offset_seconds (csr_utc_offset_seconds),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_epoch_seconds      (req_epoch_seconds),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_year               (rsp_year),
      .rsp_month              (rsp_month),
      .rsp_day_of_month       (rsp_day_of_month),
      .rsp_hour               (rsp_hour),
      .rsp_minute             (rsp_minute),
      .rsp_second             (rsp_second)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_year, rsp_month, rsp_day_of_month,
                               rsp_hour, rsp_minute, rsp_second});
         if (req_valid && req_ready) sb.note_request(req_epoch_seconds);
         if (csr_valid && csr_ready) sb.set_offset(csr_utc_offset_seconds);
      end
   end

   // response side stalls in short bursts while idling is on
   initial begin : rsp_side
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) hold = $urandom_range(1, 5);
         end
      end
   end

   function automatic logic [31:0] fit_epoch(longint v);
      if (v < 0) return 32'd0;
      if (v > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return v[31:0];
   endfunction

   // timestamps near year and month edges, plus full-range and extreme values
   function automatic logic [31:0] random_epoch(logic signed [OFFSET_W-1:0] ofs);
      int pick;
      longint base;
      longint delta;
      pick = $urandom_range(0, 99);
      delta = longint'($urandom_range(0, 180000)) - 90000;
      if ($urandom_range(0, 3) == 0) delta = $urandom_range(0, 1) ? 0 : -1;
      if (pick < 40) return $urandom;
      if (pick < 65) begin
         base = local_seconds($urandom_range(1970, 2106), 1, 1, 0, 0, 0);
      end else if (pick < 85) begin
         base = local_seconds($urandom_range(1970, 2105), $urandom_range(2, 12), 1, 0, 0, 0);
      end else if (pick < 95) begin
         return $urandom_range(0, 200000);
      end else begin
         return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      end
      return fit_epoch(base + delta - longint'(ofs));
   endfunction

   task automatic send_request(logic [31:0] epoch);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= epoch;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait for every outstanding response
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_offset(logic signed [OFFSET_W-1:0] value);
      csr_valid <= 1'b1;
      csr_utc_offset_seconds <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic signed [OFFSET_W-1:0] ofs;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_utc_offset_seconds = '0;
      req_valid = 1'b0;
      req_epoch_seconds = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset offset of +8 hours
      send_request(32'd0);
      send_request(32'd1);
      send_request(32'hFFFF_FFFF);
      send_request(fit_epoch(local_seconds(1972, 2, 29, 12, 0, 0) - 28800));
      send_request(fit_epoch(local_seconds(1972, 12, 31, 23, 59, 59) - 28800));
      send_request(fit_epoch(local_seconds(1973, 1, 1, 0, 0, 0) - 28800));
      send_request(fit_epoch(local_seconds(2000, 2, 28, 23, 59, 59) - 28800));
      send_request(fit_epoch(local_seconds(2000, 2, 29, 0, 0, 0) - 28800));
      send_request(fit_epoch(local_seconds(2000, 3, 1, 0, 0, 0) - 28800));
      send_request(fit_epoch(local_seconds(2100, 2, 28, 23, 59, 59) - 28800));
      send_request(fit_epoch(local_seconds(2100, 3, 1, 0, 0, 0) - 28800));
      send_request(fit_epoch(local_seconds(2104, 12, 31, 23, 59, 59) - 28800));
      send_request(fit_epoch(local_seconds(2038, 6, 30, 23, 59, 59) - 28800));
      send_request(fit_epoch(local_seconds(2024, 7, 31, 23, 59, 59) - 28800));

      // negative local time clamps to the epoch
      drain_requests();
      write_offset(-17'sd43200);
      send_request(32'd0);
      send_request(32'd43199);
      send_request(32'd43200);
      send_request(32'd43201);

      // offsets beyond the nominal range apply as written
      drain_requests();
      write_offset(17'sd65535);
      send_request(32'hFFFF_FFFF);
      send_request(32'd0);
      drain_requests();
      write_offset(-17'sd65536);
      send_request(32'd65535);
      send_request(32'd65536);
      send_request(32'hFFFF_FFFF);

      for (int p = 0; p < 9; p++) begin
         drain_requests();
         case (p)
            0: ofs = 17'sd28800;
            1: ofs = 17'sd0;
            2: ofs = -17'sd43200;
            3: ofs = 17'sd50400;
            4: ofs = -17'sd65536;
            5: ofs = 17'sd65535;
            6: ofs = 17'($urandom_range(0, 93600) - 43200);
            7: ofs = -17'sd1;
            default: ofs = 17'($urandom);
         endcase
         write_offset(ofs);
         // no idling on the last phase
         if (p == 8 || p % 3 == 0) idle_pct = 0;
         else if (p % 3 == 1) idle_pct = 10;
         else idle_pct = 35;
         for (int n = 0; n < 170; n++) begin
            if (n == 85) drain_requests();
            send_request(random_epoch(ofs));
         end
      end

      drain_requests();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_epoch_seconds_to_calendar_unit: done, clean");
      end else begin
         $display("tb_epoch_seconds_to_calendar_unit: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb_epoch_seconds_to_calendar_unit: done, errors");
      $finish;
   end

endmodule
